/* hw/rtl/depth_tested_pixel_write_assert.svh */
// Assertion macros for the depth-tested pixel write block.
// Each macro samples on clk_i and is switched off while rst_ni is low.
`ifndef DEPTH_TESTED_PIXEL_WRITE_ASSERT_SVH
`define DEPTH_TESTED_PIXEL_WRITE_ASSERT_SVH

// A property that must hold in the same cycle as its antecedent.
`define DTPW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A consequent that must hold in the cycle after the antecedent.
`define DTPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dtpw_pkg.sv */
package dtpw_pkg;

  localparam int unsigned CfgW     = 9;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned ChanW    = 9;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned DepthInW = 24;

  localparam logic [CfgW-1:0] FrameReset = 9'd256;

  typedef enum logic [1:0] {
    CMD_WRITE_RGB    = 2'd0,
    CMD_WRITE_PACKED = 2'd1,
    CMD_CLEAR        = 2'd2,
    CMD_READ         = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_ADDR,
    S_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              drawn;
    logic              clipped;
    logic [ColorW-1:0]   color;
    logic [DepthInW-1:0] depth;
  } res_t;

  // Clamp a Q1.8 channel at 1.0 and scale by 255 with truncation.
  // For 0 < c < 256 the scaled value is exactly c - 1.
  function automatic logic [ByteW-1:0] chan_to_byte(input logic [ChanW-1:0] c);
    logic [ByteW-1:0] b;
    if (c[ChanW-1]) begin
      b = {ByteW{1'b1}};
    end else if (c == '0) begin
      b = '0;
    end else begin
      b = c[ByteW-1:0] - ByteW'(1);
    end
    return b;
  endfunction

endpackage

/* hw/rtl/depth_tested_pixel_write.sv */
// Depth-tested pixel write block. It takes one pixel command as an item
// and returns one result item for it. A write or read whose coordinates fall
// outside the configured frame is reported as clipped; otherwise it addresses
// entry y*width+x of a depth store and a colour store, both synchronous RAMs
// of MAX_WIDTH*MAX_HEIGHT entries. A write is kept when its depth is no
// greater than the stored depth, and then both depth and colour are replaced.
// Sequence: an unclipped write or read passes through capture, row multiply,
// RAM read, depth compare and write back, and result load, following the
// order of the stores' single read and write ports; the block takes no new
// item until it has loaded the last one's result, and the result load waits
// while the output register holds a stalled result. A clipped item goes from
// capture straight to result load. A clear command sweeps both stores one
// entry a cycle and then delivers its result. After reset the same clearing
// pass runs with in_stall_o held high; configuration writes are taken at any
// time, but should only be made while the block is idle. A finished result
// waits in an output register, so the block can take the next item while the
// downstream side stalls.
module depth_tested_pixel_write #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned DEPTH_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [dtpw_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         cmd_i,
  input  logic signed [dtpw_pkg::CoordW-1:0] x_pos_i,
  input  logic signed [dtpw_pkg::CoordW-1:0] y_pos_i,
  input  logic [dtpw_pkg::DepthInW-1:0]      depth_in_i,
  input  logic [dtpw_pkg::ChanW-1:0]         red_i,
  input  logic [dtpw_pkg::ChanW-1:0]         green_i,
  input  logic [dtpw_pkg::ChanW-1:0]         blue_i,
  input  logic [dtpw_pkg::ColorW-1:0]        packed_color_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               drawn_o,
  output logic                               clipped_o,
  output logic [dtpw_pkg::ColorW-1:0]        read_color_o,
  output logic [dtpw_pkg::DepthInW-1:0]      read_depth_o
);

  // Both stores share one address space of the full frame size.
  localparam int unsigned StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1;

  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr, mem_raddr;
  logic [DEPTH_BITS-1:0]       mem_wdepth, mem_rdepth;
  logic [dtpw_pkg::ColorW-1:0] mem_wcolor, mem_rcolor;

  // The controller owns the configuration, the clip test, the address
  // arithmetic, the read-modify-write sequence and the output register.
  dtpw_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .x_pos_i        (x_pos_i),
    .y_pos_i        (y_pos_i),
    .depth_in_i     (depth_in_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .packed_color_i (packed_color_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drawn_o        (drawn_o),
    .clipped_o      (clipped_o),
    .read_color_o   (read_color_o),
    .read_depth_o   (read_depth_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdepth_o   (mem_wdepth),
    .mem_wcolor_o   (mem_wcolor),
    .mem_raddr_o    (mem_raddr),
    .mem_rdepth_i   (mem_rdepth),
    .mem_rcolor_i   (mem_rcolor)
  );

  // Depth store: farthest depth after a clearing pass.
  dtpw_ram #(
    .Width (DEPTH_BITS),
    .Depth (StoreSize)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdepth),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdepth)
  );

  // Colour store: black after a clearing pass.
  dtpw_ram #(
    .Width (dtpw_pkg::ColorW),
    .Depth (StoreSize)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wcolor),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rcolor)
  );

endmodule

/* hw/rtl/dtpw_ram.sv */
module dtpw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/dtpw_ctrl.sv */
module dtpw_ctrl #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned DEPTH_BITS = 24,
  localparam int unsigned StoreSize = MAX_WIDTH * MAX_HEIGHT,
  localparam int unsigned AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [dtpw_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [dtpw_pkg::CoordW-1:0] x_pos_i,
  input  logic signed [dtpw_pkg::CoordW-1:0] y_pos_i,
  input  logic [dtpw_pkg::DepthInW-1:0]     depth_in_i,
  input  logic [dtpw_pkg::ChanW-1:0]        red_i,
  input  logic [dtpw_pkg::ChanW-1:0]        green_i,
  input  logic [dtpw_pkg::ChanW-1:0]        blue_i,
  input  logic [dtpw_pkg::ColorW-1:0]       packed_color_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              drawn_o,
  output logic                              clipped_o,
  output logic [dtpw_pkg::ColorW-1:0]       read_color_o,
  output logic [dtpw_pkg::DepthInW-1:0]     read_depth_o,
  output logic                              mem_we_o,
  output logic [AddrW-1:0]                  mem_waddr_o,
  output logic [DEPTH_BITS-1:0]             mem_wdepth_o,
  output logic [dtpw_pkg::ColorW-1:0]       mem_wcolor_o,
  output logic [AddrW-1:0]                  mem_raddr_o,
  input  logic [DEPTH_BITS-1:0]             mem_rdepth_i,
  input  logic [dtpw_pkg::ColorW-1:0]       mem_rcolor_i
);

  localparam int unsigned XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WEW  = ($clog2(MAX_WIDTH + 1) > dtpw_pkg::CfgW) ?
                                 $clog2(MAX_WIDTH + 1) : dtpw_pkg::CfgW;
  localparam int unsigned HEW  = ($clog2(MAX_HEIGHT + 1) > dtpw_pkg::CfgW) ?
                                 $clog2(MAX_HEIGHT + 1) : dtpw_pkg::CfgW;
  localparam int unsigned CmpW0 = (WEW > HEW) ? WEW : HEW;
  localparam int unsigned CmpW  = (CmpW0 > dtpw_pkg::CoordW) ? CmpW0 : dtpw_pkg::CoordW;
  localparam int unsigned ZW   = (DEPTH_BITS > dtpw_pkg::DepthInW) ?
                                 DEPTH_BITS : dtpw_pkg::DepthInW;
  localparam int unsigned PW   = YW + WEW;

  dtpw_pkg::state_e state_q, state_d;

  logic [dtpw_pkg::CfgW-1:0] frame_width_q, frame_height_q;
  logic [AddrW-1:0]          clr_cnt_q, clr_cnt_d;
  logic                      clr_pend_q, clr_pend_d;
  logic                      out_valid_q, out_valid_d;

  dtpw_pkg::cmd_e            cmd_q;
  logic [XW-1:0]             x_q;
  logic [YW-1:0]             y_q;
  logic [DEPTH_BITS-1:0]     z_q;
  logic [dtpw_pkg::ColorW-1:0] color_q;
  logic [PW-1:0]             prod_q;
  logic [AddrW-1:0]          addr_q;
  dtpw_pkg::res_t            res_q, out_q;

  logic [WEW-1:0]  w_ext, w_eff;
  logic [HEW-1:0]  h_ext, h_eff;
  logic [CmpW-1:0] x_mag, y_mag;
  logic            clip;
  logic            accept;
  logic            out_free;
  logic            clr_last;
  logic            write_ok;
  logic [PW:0]     sum;
  logic [ZW-1:0]   z_ext, rd_ext;
  logic [dtpw_pkg::ColorW-1:0] color_in;
  dtpw_pkg::cmd_e  cmd_in;

  // Frame size limited to what the store holds.
  assign w_ext = WEW'(frame_width_q);
  assign h_ext = HEW'(frame_height_q);
  assign w_eff = (w_ext > WEW'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : w_ext;
  assign h_eff = (h_ext > HEW'(MAX_HEIGHT)) ? HEW'(MAX_HEIGHT) : h_ext;

  assign x_mag = CmpW'(x_pos_i[dtpw_pkg::CoordW-2:0]);
  assign y_mag = CmpW'(y_pos_i[dtpw_pkg::CoordW-2:0]);
  assign clip  = x_pos_i[dtpw_pkg::CoordW-1] || y_pos_i[dtpw_pkg::CoordW-1] ||
                 (x_mag >= CmpW'(w_eff)) || (y_mag >= CmpW'(h_eff));

  assign cmd_in   = dtpw_pkg::cmd_e'(cmd_i);
  assign color_in = (cmd_in == dtpw_pkg::CMD_WRITE_RGB) ?
                    {{(dtpw_pkg::ColorW - 3 * dtpw_pkg::ByteW){1'b0}},
                     dtpw_pkg::chan_to_byte(red_i),
                     dtpw_pkg::chan_to_byte(green_i),
                     dtpw_pkg::chan_to_byte(blue_i)} :
                    packed_color_i;
  assign z_ext  = ZW'(depth_in_i);
  assign rd_ext = ZW'(mem_rdepth_i);

  assign sum      = {1'b0, prod_q} + (PW + 1)'(x_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign clr_last = (clr_cnt_q == AddrW'(StoreSize - 1));
  assign write_ok = (cmd_q != dtpw_pkg::CMD_READ) && (z_q <= mem_rdepth_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtpw_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_d = clr_pend_q ? dtpw_pkg::S_DONE : dtpw_pkg::S_IDLE;
        end
      end
      dtpw_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_in == dtpw_pkg::CMD_CLEAR) begin
            state_d = dtpw_pkg::S_CLEAR;
          end else if (clip) begin
            state_d = dtpw_pkg::S_DONE;
          end else begin
            state_d = dtpw_pkg::S_MUL;
          end
        end
      end
      dtpw_pkg::S_MUL:  state_d = dtpw_pkg::S_ADDR;
      dtpw_pkg::S_ADDR: state_d = dtpw_pkg::S_CMP;
      dtpw_pkg::S_CMP:  state_d = dtpw_pkg::S_DONE;
      dtpw_pkg::S_DONE: begin
        if (out_free) begin
          state_d = dtpw_pkg::S_IDLE;
        end
      end
      default: state_d = dtpw_pkg::S_IDLE;
    endcase
  end

  // Outputs and control updates.
  always_comb begin
    in_stall_o   = (state_q != dtpw_pkg::S_IDLE);
    accept       = in_valid_i && (state_q == dtpw_pkg::S_IDLE);
    mem_raddr_o  = sum[AddrW-1:0];
    mem_we_o     = 1'b0;
    mem_waddr_o  = addr_q;
    mem_wdepth_o = z_q;
    mem_wcolor_o = color_q;
    clr_cnt_d    = clr_cnt_q;
    clr_pend_d   = clr_pend_q;
    out_valid_d  = out_valid_q && out_stall_i;
    unique case (state_q)
      dtpw_pkg::S_CLEAR: begin
        mem_we_o     = 1'b1;
        mem_waddr_o  = clr_cnt_q;
        mem_wdepth_o = '1;
        mem_wcolor_o = '0;
        clr_cnt_d    = clr_last ? '0 : clr_cnt_q + AddrW'(1);
      end
      dtpw_pkg::S_IDLE: begin
        if (accept && (cmd_in == dtpw_pkg::CMD_CLEAR)) begin
          clr_cnt_d  = '0;
          clr_pend_d = 1'b1;
        end
      end
      dtpw_pkg::S_CMP: begin
        mem_we_o = write_ok;
      end
      dtpw_pkg::S_DONE: begin
        clr_pend_d = 1'b0;
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= dtpw_pkg::S_CLEAR;
      clr_cnt_q      <= '0;
      clr_pend_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      frame_width_q  <= dtpw_pkg::FrameReset;
      frame_height_q <= dtpw_pkg::FrameReset;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_pend_q  <= clr_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (dtpw_pkg::cfg_idx_e'(cfg_idx_i))
          dtpw_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
          dtpw_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q       <= cmd_in;
      x_q         <= x_pos_i[XW-1:0];
      y_q         <= y_pos_i[YW-1:0];
      z_q         <= z_ext[DEPTH_BITS-1:0];
      color_q     <= color_in;
      res_q       <= '{drawn:   1'b0,
                       clipped: clip && (cmd_in != dtpw_pkg::CMD_CLEAR),
                       color:   '0,
                       depth:   '0};
    end
    if (state_q == dtpw_pkg::S_MUL) begin
      prod_q <= PW'(y_q) * PW'(w_eff);
    end
    if (state_q == dtpw_pkg::S_ADDR) begin
      addr_q <= mem_raddr_o;
    end
    // Only an unclipped item reaches the compare, so clipped stays low here.
    if (state_q == dtpw_pkg::S_CMP) begin
      if (cmd_q == dtpw_pkg::CMD_READ) begin
        res_q <= '{drawn:   1'b0,
                   clipped: 1'b0,
                   color:   mem_rcolor_i,
                   depth:   rd_ext[dtpw_pkg::DepthInW-1:0]};
      end else begin
        res_q <= '{drawn: write_ok, clipped: 1'b0, color: '0, depth: '0};
      end
    end
    if ((state_q == dtpw_pkg::S_DONE) && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign drawn_o      = out_q.drawn;
  assign clipped_o    = out_q.clipped;
  assign read_color_o = out_q.color;
  assign read_depth_o = out_q.depth;

endmodule

/* hw/rtl/dtpw_chk.sv */
`include "depth_tested_pixel_write_assert.svh"

module dtpw_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          drawn_o,
  input logic                          clipped_o,
  input logic [dtpw_pkg::ColorW-1:0]   read_color_o,
  input logic [dtpw_pkg::DepthInW-1:0] read_depth_o
);

  // A clipped item is never drawn.
  `DTPW_ASSERT(a_drawn_not_clipped, out_valid_o |-> !(drawn_o && clipped_o), "drawn and clipped")

  // Only an unclipped read carries stored data; checked on drawn and clipped results.
  `DTPW_ASSERT(a_no_data_on_write, (out_valid_o && (drawn_o || clipped_o)) |-> ((read_color_o == '0) && (read_depth_o == '0)), "read data on a non-read result")

  // Items are worked on one at a time.
  `DTPW_ASSERT_NEXT(a_one_item, in_valid_i && !in_stall_o, in_stall_o, "item accepted while busy")

  // A stalled result holds.
  `DTPW_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(drawn_o) && $stable(clipped_o) && $stable(read_color_o) && $stable(read_depth_o), "stalled result changed")

endmodule

bind depth_tested_pixel_write dtpw_chk u_dtpw_chk (.*);

/* test/tb.sv */
module tb;
  import dtpw_pkg::*;

  // Size of both stores and the largest frame edge the block can address.
  localparam int unsigned MaxDim      = 256;
  localparam int unsigned StoreSize   = MaxDim * MaxDim;
  localparam logic [DepthInW-1:0] FarDepth = {DepthInW{1'b1}};
  // A clear sweeps the whole store with nothing accepted on either side, and
  // so does the clearing pass after reset; the watchdog allows for several.
  localparam int unsigned IdleLimit   = 4 * StoreSize;
  localparam int unsigned RandomItems = 1250;
  localparam int unsigned NumPhases   = 10;
  localparam int unsigned MaxClears   = 3;

  typedef struct {
    cmd_e                       cmd;
    logic signed [CoordW-1:0]   x;
    logic signed [CoordW-1:0]   y;
    logic        [DepthInW-1:0] depth;
    logic        [ChanW-1:0]    red;
    logic        [ChanW-1:0]    green;
    logic        [ChanW-1:0]    blue;
    logic        [ColorW-1:0]   packed_color;
  } pixel_t;

  // One row of the directed table: the pixel command, and where the outcome
  // is obvious, the result item typed in by hand.
  typedef struct {
    pixel_t px;
    bit     typed;
    res_t   result;
  } dir_row_t;

  logic                       clk_i;
  logic                       rst_ni         = 1'b0;
  logic                       cfg_we_i       = 1'b0;
  logic                       cfg_idx_i      = CFG_FRAME_WIDTH;
  logic [CfgW-1:0]            cfg_data_i     = '0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 cmd_i          = CMD_READ;
  logic signed [CoordW-1:0]   x_pos_i        = '0;
  logic signed [CoordW-1:0]   y_pos_i        = '0;
  logic [DepthInW-1:0]        depth_in_i     = '0;
  logic [ChanW-1:0]           red_i          = '0;
  logic [ChanW-1:0]           green_i        = '0;
  logic [ChanW-1:0]           blue_i         = '0;
  logic [ColorW-1:0]          packed_color_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i    = 1'b0;
  logic                       drawn_o;
  logic                       clipped_o;
  logic [ColorW-1:0]          read_color_o;
  logic [DepthInW-1:0]        read_depth_o;

  depth_tested_pixel_write u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Shadow copy of the frame: depth and colour per pixel, and the frame size
  // as last written to the registers.
  logic [DepthInW-1:0] depth_mem [StoreSize];
  logic [ColorW-1:0]   color_mem [StoreSize];
  int unsigned         frame_w = FrameReset;
  int unsigned         frame_h = FrameReset;

  res_t        pending_results [$];
  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned n_drawn      = 0;
  int unsigned n_hidden     = 0;
  int unsigned n_clipped    = 0;
  int unsigned n_reads      = 0;
  int unsigned n_clears     = 0;
  int unsigned n_items      = 0;
  int unsigned clears_left  = MaxClears;
  logic signed [CoordW-1:0] last_x = '0;
  logic signed [CoordW-1:0] last_y = '0;

  // Clamp a Q1.8 channel at 1.0, then scale by 255 and truncate.
  function automatic logic [ByteW-1:0] scale_channel(logic [ChanW-1:0] c);
    int unsigned v;
    v = (c > 256) ? 256 : c;
    return ByteW'((v * 255) >> 8);
  endfunction

  function automatic int unsigned used_width();
    return (frame_w > MaxDim) ? MaxDim : frame_w;
  endfunction

  function automatic int unsigned used_height();
    return (frame_h > MaxDim) ? MaxDim : frame_h;
  endfunction

  // True when (x,y) lies inside the usable frame; addr is then its entry.
  function automatic bit pixel_addr(logic signed [CoordW-1:0] x,
                                    logic signed [CoordW-1:0] y,
                                    output int unsigned addr);
    int xi;
    int yi;
    xi   = x;
    yi   = y;
    addr = 0;
    if (xi < 0 || yi < 0 || xi >= int'(used_width()) || yi >= int'(used_height())) begin
      return 1'b0;
    end
    addr = yi * used_width() + xi;
    return 1'b1;
  endfunction

  function automatic void wipe_frame();
    for (int i = 0; i < StoreSize; i++) begin
      depth_mem[i] = FarDepth;
      color_mem[i] = '0;
    end
  endfunction

  // Applies one pixel command to the shadow frame and returns its result.
  function automatic res_t apply_pixel(pixel_t p);
    res_t        r;
    int unsigned addr;
    logic [ColorW-1:0] colour;
    r = '0;
    if (p.cmd == CMD_CLEAR) begin
      wipe_frame();
      n_clears++;
    end else if (!pixel_addr(p.x, p.y, addr)) begin
      r.clipped = 1'b1;
      n_clipped++;
    end else if (p.cmd == CMD_READ) begin
      r.color = color_mem[addr];
      r.depth = depth_mem[addr];
      n_reads++;
    end else begin
      colour = (p.cmd == CMD_WRITE_RGB) ?
               {8'h00, scale_channel(p.red), scale_channel(p.green), scale_channel(p.blue)} :
               p.packed_color;
      // An equal depth wins, so the later of two coincident writes is kept.
      if (p.depth <= depth_mem[addr]) begin
        depth_mem[addr] = p.depth;
        color_mem[addr] = colour;
        r.drawn = 1'b1;
        n_drawn++;
      end else begin
        n_hidden++;
      end
    end
    return r;
  endfunction

  function automatic dir_row_t dir_row(cmd_e cmd, int x, int y, logic [DepthInW-1:0] z,
                                       logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                       logic [ChanW-1:0] b, logic [ColorW-1:0] pk,
                                       bit typed, logic dr, logic cl,
                                       logic [ColorW-1:0] col, logic [DepthInW-1:0] dep);
    dir_row_t row;
    row.px.cmd          = cmd;
    row.px.x            = CoordW'(x);
    row.px.y            = CoordW'(y);
    row.px.depth        = z;
    row.px.red          = r;
    row.px.green        = g;
    row.px.blue         = b;
    row.px.packed_color = pk;
    row.typed           = typed;
    row.result          = '{dr, cl, col, dep};
    return row;
  endfunction

  // Random pixel commands. Most land inside the frame, and many revisit the
  // last written pixel with a depth near the stored one, so that both sides
  // of the depth test and the equal case are reached often.
  function automatic pixel_t random_pixel();
    pixel_t      p;
    int unsigned roll;
    int unsigned w;
    int unsigned h;
    int unsigned addr;
    int          stored;
    w    = used_width();
    h    = used_height();
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      p.cmd = CMD_WRITE_RGB;
    end else if (roll < 70) begin
      p.cmd = CMD_WRITE_PACKED;
    end else if (roll < 99 || clears_left == 0) begin
      p.cmd = CMD_READ;
    end else begin
      p.cmd = CMD_CLEAR;
      clears_left--;
    end
    p.red          = $urandom_range(0, 511);
    p.green        = $urandom_range(0, 511);
    p.blue         = $urandom_range(0, 511);
    p.packed_color = $urandom();
    p.depth        = DepthInW'($urandom());

    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      p.x = CoordW'($urandom());
      p.y = CoordW'($urandom());
    end else if (roll < 25) begin
      // Just past an edge of the frame.
      p.x = $urandom_range(0, 1) ? CoordW'(w + $urandom_range(0, 2)) :
                                   CoordW'(-1 - int'($urandom_range(0, 2)));
      p.y = (h == 0) ? CoordW'(0) : CoordW'($urandom_range(0, h - 1));
      if ($urandom_range(0, 1)) begin
        p.y = $urandom_range(0, 1) ? CoordW'(h + $urandom_range(0, 2)) :
                                     CoordW'(-1 - int'($urandom_range(0, 2)));
        p.x = (w == 0) ? CoordW'(0) : CoordW'($urandom_range(0, w - 1));
      end
    end else if (roll < 60) begin
      p.x = last_x;
      p.y = last_y;
    end else begin
      p.x = (w == 0) ? CoordW'($urandom_range(0, 3)) : CoordW'($urandom_range(0, w - 1));
      p.y = (h == 0) ? CoordW'($urandom_range(0, 3)) : CoordW'($urandom_range(0, h - 1));
    end

    if (pixel_addr(p.x, p.y, addr)) begin
      stored = depth_mem[addr];
      roll   = $urandom_range(0, 99);
      if (roll < 25) begin
        p.depth = DepthInW'(stored);
      end else if (roll < 45) begin
        p.depth = DepthInW'((stored > 0) ? stored - 1 : 0);
      end else if (roll < 60) begin
        p.depth = DepthInW'((stored < int'(FarDepth)) ? stored + 1 : stored);
      end else if (roll < 75) begin
        p.depth = DepthInW'((stored > 4096) ? stored - int'($urandom_range(0, 4096)) : 0);
      end else if (roll < 85) begin
        p.depth = $urandom_range(0, 1) ? FarDepth : '0;
      end
    end
    if (p.cmd == CMD_WRITE_RGB || p.cmd == CMD_WRITE_PACKED) begin
      last_x = p.x;
      last_y = p.y;
    end
    return p;
  endfunction

  // Offers one item after a random gap and waits for it to be taken. The
  // expected result is worked out at the edge that accepts the item.
  task automatic send_pixel(input pixel_t p, input bit typed, input res_t typed_result);
    int unsigned roll;
    int unsigned gap;
    res_t        predicted;
    roll = $urandom_range(0, 19);
    gap  = (roll < 12) ? 0 : (roll < 18) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i          <= p.cmd;
    x_pos_i        <= p.x;
    y_pos_i        <= p.y;
    depth_in_i     <= p.depth;
    red_i          <= p.red;
    green_i        <= p.green;
    blue_i         <= p.blue;
    packed_color_i <= p.packed_color;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_pixel(p);
    if (typed) begin
      predicted = typed_result;
    end
    pending_results = {pending_results, predicted};
    n_items++;
  endtask

  // Holds the input side off until every outstanding result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FRAME_WIDTH;
    cfg_data_i <= CfgW'(w);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FRAME_HEIGHT;
    cfg_data_i <= CfgW'(h);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    frame_w    = w;
    frame_h    = h;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    dir_row_t    rows [$];
    int unsigned phase_w [NumPhases];
    int unsigned phase_h [NumPhases];
    int unsigned per_phase;

    wipe_frame();
    // Frame sizes per phase: a single pixel, zero width and zero height,
    // oversized in both directions (used as the largest frame), thin strips,
    // odd sizes, and two drawn at random.
    phase_w = '{1, 0, 9, 511, 3, 256, 17, 2, 0, 0};
    phase_h = '{1, 5, 0, 511, 200, 1, 13, 2, 0, 0};
    phase_w[8] = $urandom_range(1, 300);
    phase_h[8] = $urandom_range(1, 300);
    phase_w[9] = $urandom_range(1, 300);
    phase_h[9] = $urandom_range(1, 300);

    // Directed table, run with the frame size left at its reset value.
    //                       cmd               x       y       depth      r    g    b    packed
    rows = {rows, dir_row(CMD_READ,          0,      0, 24'h000000,   0,   0,   0, 32'h0,
                          1, 1'b0, 1'b0, 32'h0, FarDepth)};
    rows = {rows, dir_row(CMD_WRITE_RGB,     0,      0, FarDepth,   256,   0, 511, 32'h0,
                          0, 1'b0, 1'b0, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_READ,          0,      0, 24'h000000,   0,   0,   0, 32'h0,
                          0, 1'b0, 1'b0, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_WRITE_PACKED,255,    255, 24'h000000,   0,   0,   0, 32'hFFFFFFFF,
                          0, 1'b0, 1'b0, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_WRITE_PACKED,255,    255, 24'h000001, 511, 511, 511, 32'h12345678,
                          0, 1'b0, 1'b0, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_READ,        255,    255, 24'h000000,   0,   0,   0, 32'h0,
                          0, 1'b0, 1'b0, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_WRITE_RGB,    -1,      0, 24'h000000,   1,   1,   1, 32'h0,
                          1, 1'b0, 1'b1, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_WRITE_PACKED,256,      0, 24'h000000,   0,   0,   0, 32'hA5A5A5A5,
                          1, 1'b0, 1'b1, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_WRITE_RGB,     0,    256, 24'h000000, 256, 256, 256, 32'h0,
                          1, 1'b0, 1'b1, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_READ,      32767, -32768, 24'h000000,   0,   0,   0, 32'h0,
                          1, 1'b0, 1'b1, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_READ,     -32768,  32767, FarDepth,   511, 511, 511, 32'hFFFFFFFF,
                          1, 1'b0, 1'b1, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_WRITE_RGB,    10,     20, 24'h800000,   1, 255, 257, 32'h0,
                          0, 1'b0, 1'b0, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_WRITE_PACKED, 10,     20, 24'h800000,   0,   0,   0, 32'h00C0FFEE,
                          0, 1'b0, 1'b0, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_WRITE_RGB,    10,     20, 24'h800001, 128, 129, 255, 32'h0,
                          0, 1'b0, 1'b0, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_READ,         10,     20, 24'h000000,   0,   0,   0, 32'h0,
                          0, 1'b0, 1'b0, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_CLEAR,     -32768, -32768, FarDepth,  511, 511, 511, 32'hFFFFFFFF,
                          1, 1'b0, 1'b0, 32'h0, 24'h0)};
    rows = {rows, dir_row(CMD_READ,         10,     20, 24'h000000,   0,   0,   0, 32'h0,
                          1, 1'b0, 1'b0, 32'h0, FarDepth)};
    rows = {rows, dir_row(CMD_READ,        255,    255, 24'h000000,   0,   0,   0, 32'h0,
                          1, 1'b0, 1'b0, 32'h0, FarDepth)};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block holds in_stall_o high during its clearing pass after reset,
    // so the first item simply waits for it.
    foreach (rows[i]) begin
      send_pixel(rows[i].px, rows[i].typed, rows[i].result);
    end
    drain_results();

    per_phase = RandomItems / NumPhases;
    for (int ph = 0; ph < NumPhases; ph++) begin
      set_frame(phase_w[ph], phase_h[ph]);
      repeat (per_phase) send_pixel(random_pixel(), 1'b0, '0);
      drain_results();
    end

    repeat (20) @(posedge clk_i);
    $display("Ran %0d items over %0d frame sizes, zero-sized and oversized among them.",
             n_items, NumPhases + 1);
    $display("Outcomes: %0d drawn, %0d hidden by depth, %0d clipped, %0d reads, %0d clears.",
             n_drawn, n_hidden, n_clipped, n_reads, n_clears);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // The receiving side stalls in bursts: mostly short, now and then long,
  // with occasional long stretches of no stall at all.
  initial begin : result_stall
    int unsigned run;
    int unsigned len;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30);
      repeat (run) @(posedge clk_i);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
      out_stall_i <= 1'b1;
      repeat (len) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Every result item taken is checked against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with none expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (drawn_o !== want.drawn) begin
          $error("drawn: expected %0d, got %0d", want.drawn, drawn_o);
          fail_count++;
        end
        if (clipped_o !== want.clipped) begin
          $error("clipped: expected %0d, got %0d", want.clipped, clipped_o);
          fail_count++;
        end
        if (read_color_o !== want.color) begin
          $error("read_color: expected %08h, got %08h", want.color, read_color_o);
          fail_count++;
        end
        if (read_depth_o !== want.depth) begin
          $error("read_depth: expected %06h, got %06h", want.depth, read_depth_o);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if neither side moves an item for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $error("no item moved for %0d cycles", IdleLimit);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/dtpw_pkg.sv
hw/rtl/dtpw_ram.sv
hw/rtl/dtpw_ctrl.sv
hw/rtl/depth_tested_pixel_write.sv
hw/rtl/dtpw_chk.sv
test/tb.sv
